### sv/hbad_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hbad_pkg
// Shared types and constants of the handheld bus address decoder: the
// request and response payloads, the configuration set and the region codes.
// ----------------------------------------------------------------------------
package hbad_pkg;

    // Access direction.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Access sizes; the unused fourth code is treated as a word.
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;
    localparam logic [1:0] SZ_WIDE = 2'd3;

    // Address regions, taken from the top byte of the bus address.
    localparam logic [7:0] RGN_BIOS   = 8'h00;
    localparam logic [7:0] RGN_WRAM   = 8'h02;
    localparam logic [7:0] RGN_IRAM   = 8'h03;
    localparam logic [7:0] RGN_IO     = 8'h04;
    localparam logic [7:0] RGN_PAL    = 8'h05;
    localparam logic [7:0] RGN_VRAM   = 8'h06;
    localparam logic [7:0] RGN_OAM    = 8'h07;
    localparam logic [7:0] RGN_ROM0   = 8'h08;
    localparam logic [7:0] RGN_ROM1   = 8'h09;
    localparam logic [7:0] RGN_ROM2   = 8'h0A;
    localparam logic [7:0] RGN_ROM3   = 8'h0B;
    localparam logic [7:0] RGN_ROM4   = 8'h0C;
    localparam logic [7:0] RGN_EEPROM = 8'h0D;
    localparam logic [7:0] RGN_SAVE   = 8'h0E;

    // Fixed addresses and bounds.
    localparam logic [31:0] BIOS_LIMIT   = 32'h0000_4000;
    localparam logic [31:0] IO_LIMIT     = 32'h0400_0400;
    localparam logic [31:0] RTC_ADDR_A   = 32'h0800_00C4;
    localparam logic [31:0] RTC_ADDR_B   = 32'h0800_00C6;
    localparam logic [31:0] RTC_ADDR_C   = 32'h0800_00C8;
    localparam logic [31:0] DEV_MASK     = 32'h01FF_FFFF;
    localparam logic [31:0] BIOS_MASK    = 32'h0000_3FFF;
    localparam logic [31:0] IRAM_MASK    = 32'h0000_7FFF;
    localparam logic [31:0] SMALL_MASK   = 32'h0000_03FF;
    localparam logic [16:0] VRAM_MASK    = 17'h1_FFFF;
    localparam logic [16:0] VRAM_MIRROR  = 17'h1_7FFF;
    localparam logic [16:0] OBJ_BOUND_TX = 17'h1_0000;
    localparam logic [16:0] OBJ_BOUND_BM = 17'h1_4000;
    localparam logic [2:0]  BG_MODE_MAX_TILED = 3'd2;
    localparam logic [3:0]  SENSOR_FIRST = 4'h2;
    localparam logic [3:0]  SENSOR_LAST  = 4'h5;

    // Result target codes.
    typedef enum logic [4:0] {
        TGT_BIOS   = 5'd0,
        TGT_LATCH  = 5'd1,
        TGT_WRAM   = 5'd2,
        TGT_IRAM   = 5'd3,
        TGT_IO     = 5'd4,
        TGT_PAL    = 5'd5,
        TGT_VRAM   = 5'd6,
        TGT_OAM    = 5'd7,
        TGT_ROM    = 5'd8,
        TGT_EEPROM = 5'd9,
        TGT_SAVE   = 5'd10,
        TGT_RTC    = 5'd11,
        TGT_PRINT  = 5'd12,
        TGT_SENSOR = 5'd13,
        TGT_OBPC   = 5'd14,
        TGT_OBDMA  = 5'd15,
        TGT_NONE   = 5'd16
    } target_t;

    // One bus access request.
    typedef struct packed {
        logic        op;
        logic [1:0]  access_size;
        logic [31:0] bus_address;
        logic [31:0] write_data;
        logic        pc_outside_bios;
        logic        arm_mode;
        logic        dma_open_bus;
    } req_t;

    // One decode result.
    typedef struct packed {
        target_t     target;
        logic [24:0] offset;
        logic [3:0]  byte_lanes;
        logic [31:0] lane_data;
        logic [1:0]  rotate_bytes;
        logic        zero_result;
    } resp_t;

    // Configuration set seen by the decoder.
    typedef struct packed {
        logic [2:0] bg_mode;
        logic       eeprom_enable;
        logic       flash_enable;
        logic       sram_enable;
        logic       sensor_enable;
        logic       eeprom_busy;
        logic       save_type_blocks_byte;
    } cfg_t;

endpackage
`default_nettype wire

### sv/handheld_bus_address_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// handheld_bus_address_decoder
// Decodes one bus access into a target region, a masked offset, write byte
// lanes and a read rotation, under APB-programmed save and display settings.
// ----------------------------------------------------------------------------
// The block takes one request per clock unless out_ready stalls it. An
// accepted request is held in an input register, decoded by one level of
// compare-and-mask logic, and captured in the result register when it is free.
// out_valid then rises. With out_ready held high a new request is taken every
// cycle. While a finished result waits for out_ready, the input register can
// still take one more request; after that in_ready stays low until the result
// is taken, so the pipeline holds at most two requests. Configuration should
// be written only while no request is in flight.
module handheld_bus_address_decoder #(
    parameter int ROM_OFFSET_BITS  = 25,
    parameter int WRAM_OFFSET_BITS = 18
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire hbad_pkg::req_t     in_req,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output hbad_pkg::resp_t         out_resp,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import hbad_pkg::*;

    cfg_t  cfg;
    req_t  s1_req_reg;
    logic  s1_valid_reg;
    logic  s1_valid_next;
    resp_t out_resp_reg;
    logic  out_valid_reg;
    logic  out_valid_next;
    resp_t dec_resp;
    logic  in_take;
    logic  s2_free;
    logic  s1_move;

    // Configuration registers.
    hbad_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Decode logic between the input and result registers.
    hbad_decode #(
        .ROM_OFFSET_BITS  (ROM_OFFSET_BITS),
        .WRAM_OFFSET_BITS (WRAM_OFFSET_BITS)
    ) u_decode (
        .req  (s1_req_reg),
        .cfg  (cfg),
        .resp (dec_resp)
    );

    // Pipeline handshake.
    assign s2_free   = !out_valid_reg || out_ready;
    assign s1_move   = s1_valid_reg && s2_free;
    assign in_ready  = !s1_valid_reg || s2_free;
    assign in_take   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_resp  = out_resp_reg;

    always_comb
    begin
        s1_valid_next  = in_take ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_move ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_req_reg <= in_req;
        end
        if (s1_move)
        begin
            out_resp_reg <= dec_resp;
        end
    end

`ifndef SYNTHESIS
    // A held input request stays put until the result stage frees up.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |=> (s1_valid_reg && $stable(s1_req_reg)))
        else $error("input register changed while stalled");

    // A target of none carries no offset and no write lanes.
    a_none_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_resp_reg.target == TGT_NONE)) |->
        ((out_resp_reg.offset == 25'd0) && (out_resp_reg.byte_lanes == 4'd0) &&
         (out_resp_reg.lane_data == 32'd0)))
        else $error("target none with nonzero payload");

    // The zero-result hole is only reported with target none and no rotation.
    a_zero_hole: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_resp_reg.zero_result) |->
        ((out_resp_reg.target == TGT_NONE) && (out_resp_reg.rotate_bytes == 2'd0)))
        else $error("zero result outside the VRAM hole");

    // Reads rotate and writes drive lanes, never both.
    a_rot_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_resp_reg.rotate_bytes != 2'd0)) |->
        (out_resp_reg.byte_lanes == 4'd0))
        else $error("rotation given together with write lanes");
`endif

endmodule
`default_nettype wire

### sv/hbad_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hbad_cfg_regs
// APB-style configuration registers. Register i sits at byte address 4*i;
// writes to addresses past the last register are ignored and read as zero.
// ----------------------------------------------------------------------------
module hbad_cfg_regs (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    output hbad_pkg::cfg_t          cfg
);
    import hbad_pkg::*;

    localparam logic [2:0] IDX_BG_MODE    = 3'd0;
    localparam logic [2:0] IDX_EEPROM_EN  = 3'd1;
    localparam logic [2:0] IDX_FLASH_EN   = 3'd2;
    localparam logic [2:0] IDX_SRAM_EN    = 3'd3;
    localparam logic [2:0] IDX_SENSOR_EN  = 3'd4;
    localparam logic [2:0] IDX_EEPROM_BSY = 3'd5;
    localparam logic [2:0] IDX_BLOCK_BYTE = 3'd6;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] index;
    logic       wr_en;

    assign index  = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Next register value for a completed write.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (index)
                IDX_BG_MODE:    cfg_next.bg_mode               = pwdata[2:0];
                IDX_EEPROM_EN:  cfg_next.eeprom_enable         = pwdata[0];
                IDX_FLASH_EN:   cfg_next.flash_enable          = pwdata[0];
                IDX_SRAM_EN:    cfg_next.sram_enable           = pwdata[0];
                IDX_SENSOR_EN:  cfg_next.sensor_enable         = pwdata[0];
                IDX_EEPROM_BSY: cfg_next.eeprom_busy           = pwdata[0];
                IDX_BLOCK_BYTE: cfg_next.save_type_blocks_byte = pwdata[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read-back mux.
    always_comb
    begin
        case (index)
            IDX_BG_MODE:    prdata = {29'd0, cfg_reg.bg_mode};
            IDX_EEPROM_EN:  prdata = {31'd0, cfg_reg.eeprom_enable};
            IDX_FLASH_EN:   prdata = {31'd0, cfg_reg.flash_enable};
            IDX_SRAM_EN:    prdata = {31'd0, cfg_reg.sram_enable};
            IDX_SENSOR_EN:  prdata = {31'd0, cfg_reg.sensor_enable};
            IDX_EEPROM_BSY: prdata = {31'd0, cfg_reg.eeprom_busy};
            IDX_BLOCK_BYTE: prdata = {31'd0, cfg_reg.save_type_blocks_byte};
            default:        prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

### sv/hbad_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hbad_decode
// Combinational decode of one registered request into a target, a masked
// offset, write lanes and a read rotation.
// ----------------------------------------------------------------------------
module hbad_decode #(
    parameter int ROM_OFFSET_BITS  = 25,
    parameter int WRAM_OFFSET_BITS = 18
) (
    input  wire hbad_pkg::req_t  req,
    input  wire hbad_pkg::cfg_t  cfg,
    output hbad_pkg::resp_t      resp
);
    import hbad_pkg::*;

    localparam logic [31:0] RomMask  = 32'((64'd1 << ROM_OFFSET_BITS) - 64'd1);
    localparam logic [31:0] WramMask = 32'((64'd1 << WRAM_OFFSET_BITS) - 64'd1);

    typedef struct packed {
        logic [3:0]  lanes;
        logic [31:0] data;
    } lane_t;

    // Byte-lane placement of a normal write.
    function automatic lane_t put_lanes(input logic [1:0] sz, input logic [1:0] lo,
                                        input logic [31:0] v);
        lane_t r;
        case (sz)
            SZ_WORD:
            begin
                r.lanes = 4'hF;
                r.data  = v;
            end
            SZ_HALF:
            begin
                r.lanes = lo[1] ? 4'hC : 4'h3;
                r.data  = lo[1] ? {v[15:0], 16'd0} : {16'd0, v[15:0]};
            end
            default:
            begin
                r.lanes = 4'(4'h1 << lo);
                r.data  = 32'({24'd0, v[7:0]} << {lo, 3'd0});
            end
        endcase
        return r;
    endfunction

    // Byte write that is duplicated over a halfword.
    function automatic lane_t put_dup(input logic lo1, input logic [7:0] b);
        lane_t r;
        r.lanes = lo1 ? 4'hC : 4'h3;
        r.data  = lo1 ? {b, b, 16'd0} : {16'd0, b, b};
        return r;
    endfunction

    // The bitmap hole in the upper VRAM range.
    function automatic logic vram_hole(input logic [16:0] x, input logic [2:0] mode);
        return (mode > BG_MODE_MAX_TILED) && (x[16:14] == 3'b110);
    endfunction

    // The upper 32 KiB mirror onto the 32 KiB above 64 KiB.
    function automatic logic [16:0] vram_mirror(input logic [16:0] x);
        return (x[16:15] == 2'b11) ? (x & VRAM_MIRROR) : x;
    endfunction

    logic [1:0]  sz;
    logic [31:0] a;
    logic [31:0] a_am;
    logic [1:0]  rot;
    logic [7:0]  region;
    logic        is_rtc;
    logic [16:0] vr_word;
    logic [16:0] vr_byte;
    logic [16:0] vb_mapped;
    logic [16:0] obj_bound;
    logic        save_ok;
    logic        sensor_hit;
    logic [24:0] dev_off;
    resp_t       ob;
    lane_t       ln;
    lane_t       dp;

    // Common address terms.
    always_comb
    begin
        sz      = (req.access_size == SZ_WIDE) ? SZ_WORD : req.access_size;
        a       = req.bus_address;
        region  = a[31:24];
        case (sz)
            SZ_WORD: a_am = {a[31:2], 2'b00};
            SZ_HALF: a_am = {a[31:1], 1'b0};
            default: a_am = a;
        endcase
        case (sz)
            SZ_WORD: rot = a[1:0];
            SZ_HALF: rot = {1'b0, a[0]};
            default: rot = 2'd0;
        endcase
        is_rtc     = (sz == SZ_HALF) &&
                     ((a == RTC_ADDR_A) || (a == RTC_ADDR_B) || (a == RTC_ADDR_C));
        dev_off    = 25'(a & DEV_MASK);
        vr_word    = a_am[16:0] & VRAM_MASK;
        vr_byte    = {a[16:1], 1'b0};
        vb_mapped  = vram_mirror(vr_byte);
        obj_bound  = (cfg.bg_mode > BG_MODE_MAX_TILED) ? OBJ_BOUND_BM : OBJ_BOUND_TX;
        save_ok    = !cfg.eeprom_busy || cfg.flash_enable || cfg.sram_enable;
        // The sensor window decodes address bit 15 and bits 11:8 only.
        sensor_hit = (sz == SZ_BYTE) && cfg.sensor_enable && a[15] &&
                     (a[11:8] >= SENSOR_FIRST) && (a[11:8] <= SENSOR_LAST);
        ln         = put_lanes(sz, a[1:0], req.write_data);
        dp         = put_dup(a[1], req.write_data[7:0]);
    end

    // Open-bus result for reads that hit nothing.
    always_comb
    begin
        ob              = '0;
        ob.rotate_bytes = rot;
        if (req.dma_open_bus)
        begin
            ob.target = TGT_OBDMA;
        end
        else
        begin
            ob.target = TGT_OBPC;
            case (sz)
                SZ_WORD: ob.offset = 25'd0;
                SZ_HALF: ob.offset = req.arm_mode ? {23'd0, a[1], 1'b0} : 25'd0;
                default: ob.offset = req.arm_mode ? {23'd0, a[1:0]} : {24'd0, a[0]};
            endcase
        end
    end

    // Region decode.
    always_comb
    begin
        resp        = '0;
        resp.target = TGT_NONE;
        if (req.op == OP_READ)
        begin
            case (region)
                RGN_BIOS:
                begin
                    if (!req.pc_outside_bios)
                    begin
                        resp.target       = TGT_BIOS;
                        resp.offset       = 25'(a_am & BIOS_MASK);
                        resp.rotate_bytes = rot;
                    end
                    else if (a < BIOS_LIMIT)
                    begin
                        resp.target       = TGT_LATCH;
                        resp.offset       = {23'd0, a_am[1:0]};
                        resp.rotate_bytes = rot;
                    end
                    else
                    begin
                        resp = ob;
                    end
                end
                RGN_WRAM:
                begin
                    resp.target       = TGT_WRAM;
                    resp.offset       = 25'(a_am & WramMask);
                    resp.rotate_bytes = rot;
                end
                RGN_IRAM:
                begin
                    resp.target       = TGT_IRAM;
                    resp.offset       = 25'(a_am & IRAM_MASK);
                    resp.rotate_bytes = rot;
                end
                RGN_IO:
                begin
                    if (a < IO_LIMIT)
                    begin
                        resp.target       = TGT_IO;
                        resp.offset       = 25'(a_am & SMALL_MASK);
                        resp.rotate_bytes = rot;
                    end
                    else
                    begin
                        resp = ob;
                    end
                end
                RGN_PAL:
                begin
                    resp.target       = TGT_PAL;
                    resp.offset       = 25'(a_am & SMALL_MASK);
                    resp.rotate_bytes = rot;
                end
                RGN_VRAM:
                begin
                    if (vram_hole(vr_word, cfg.bg_mode))
                    begin
                        resp.zero_result = 1'b1;
                    end
                    else
                    begin
                        resp.target = TGT_VRAM;
                        resp.offset = {8'd0, vram_mirror(vr_word)};
                    end
                end
                RGN_OAM:
                begin
                    resp.target       = TGT_OAM;
                    resp.offset       = 25'(a_am & SMALL_MASK);
                    resp.rotate_bytes = rot;
                end
                RGN_ROM0, RGN_ROM1, RGN_ROM2, RGN_ROM3, RGN_ROM4:
                begin
                    if (is_rtc)
                    begin
                        resp.target = TGT_RTC;
                        resp.offset = dev_off;
                    end
                    else
                    begin
                        resp.target       = TGT_ROM;
                        resp.offset       = 25'(a_am & RomMask);
                        resp.rotate_bytes = rot;
                    end
                end
                RGN_EEPROM:
                begin
                    if (cfg.eeprom_enable)
                    begin
                        resp.target = TGT_EEPROM;
                        resp.offset = dev_off;
                    end
                    else
                    begin
                        resp = ob;
                    end
                end
                RGN_SAVE:
                begin
                    if (cfg.flash_enable || cfg.sram_enable)
                    begin
                        resp.target = TGT_SAVE;
                        resp.offset = dev_off;
                    end
                    else if (sensor_hit)
                    begin
                        resp.target = TGT_SENSOR;
                        resp.offset = {21'd0, a[11:8] - SENSOR_FIRST};
                    end
                    else
                    begin
                        resp = ob;
                    end
                end
                default:
                begin
                    resp = ob;
                end
            endcase
        end
        else
        begin
            case (region)
                RGN_WRAM:
                begin
                    resp.target     = TGT_WRAM;
                    resp.offset     = 25'(a_am & WramMask);
                    resp.byte_lanes = ln.lanes;
                    resp.lane_data  = ln.data;
                end
                RGN_IRAM:
                begin
                    resp.target     = TGT_IRAM;
                    resp.offset     = 25'(a_am & IRAM_MASK);
                    resp.byte_lanes = ln.lanes;
                    resp.lane_data  = ln.data;
                end
                RGN_IO:
                begin
                    if (a < IO_LIMIT)
                    begin
                        resp.target     = TGT_IO;
                        resp.offset     = 25'(a_am & SMALL_MASK);
                        resp.byte_lanes = ln.lanes;
                        resp.lane_data  = ln.data;
                    end
                end
                RGN_PAL:
                begin
                    resp.target = TGT_PAL;
                    if (sz == SZ_BYTE)
                    begin
                        resp.offset     = {15'd0, a[9:1], 1'b0};
                        resp.byte_lanes = dp.lanes;
                        resp.lane_data  = dp.data;
                    end
                    else
                    begin
                        resp.offset     = 25'(a_am & SMALL_MASK);
                        resp.byte_lanes = ln.lanes;
                        resp.lane_data  = ln.data;
                    end
                end
                RGN_VRAM:
                begin
                    if (sz == SZ_BYTE)
                    begin
                        // Byte writes land only in background VRAM, duplicated.
                        if (!vram_hole(vr_byte, cfg.bg_mode) && (vb_mapped < obj_bound))
                        begin
                            resp.target     = TGT_VRAM;
                            resp.offset     = {8'd0, vb_mapped};
                            resp.byte_lanes = dp.lanes;
                            resp.lane_data  = dp.data;
                        end
                    end
                    else if (!vram_hole(vr_word, cfg.bg_mode))
                    begin
                        resp.target     = TGT_VRAM;
                        resp.offset     = {8'd0, vram_mirror(vr_word)};
                        resp.byte_lanes = ln.lanes;
                        resp.lane_data  = ln.data;
                    end
                end
                RGN_OAM:
                begin
                    if (sz != SZ_BYTE)
                    begin
                        resp.target     = TGT_OAM;
                        resp.offset     = 25'(a_am & SMALL_MASK);
                        resp.byte_lanes = ln.lanes;
                        resp.lane_data  = ln.data;
                    end
                end
                RGN_ROM0, RGN_ROM1:
                begin
                    if (sz == SZ_HALF)
                    begin
                        resp.target     = is_rtc ? TGT_RTC : TGT_PRINT;
                        resp.offset     = dev_off;
                        resp.byte_lanes = 4'h3;
                        resp.lane_data  = {16'd0, req.write_data[15:0]};
                    end
                end
                RGN_EEPROM:
                begin
                    if (cfg.eeprom_enable)
                    begin
                        resp.target = TGT_EEPROM;
                        resp.offset = dev_off;
                        if (sz == SZ_WORD)
                        begin
                            resp.byte_lanes = 4'hF;
                            resp.lane_data  = req.write_data;
                        end
                        else
                        begin
                            resp.byte_lanes = 4'h1;
                            resp.lane_data  = {24'd0, req.write_data[7:0]};
                        end
                    end
                end
                RGN_SAVE:
                begin
                    if (save_ok && !((sz == SZ_BYTE) && cfg.save_type_blocks_byte))
                    begin
                        resp.target     = TGT_SAVE;
                        resp.offset     = dev_off;
                        resp.byte_lanes = 4'h1;
                        resp.lane_data  = {24'd0, req.write_data[7:0]};
                    end
                end
                default:
                begin
                    resp.target = TGT_NONE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire
